// ===== sv/fcru_pkg.sv =====
// fcru_pkg: types and fixed codes of the floppy command register unit.
// No dependencies; used by fcru_exec and floppy_command_register_unit.
package fcru_pkg;

  // item function codes (value 3 is accepted and does nothing)
  localparam logic [1:0] FUNC_PORT_RD = 2'd0;
  localparam logic [1:0] FUNC_PORT_WR = 2'd1;
  localparam logic [1:0] FUNC_BLOCK   = 2'd2;

  // port offsets
  localparam logic [2:0] PORT_STATUS = 3'd0;
  localparam logic [2:0] PORT_RTYPE  = 3'd1;
  localparam logic [2:0] PORT_ADDR_L = 3'd1;
  localparam logic [2:0] PORT_ADDR_H = 3'd2;
  localparam logic [2:0] PORT_RBYTE  = 3'd3;
  localparam logic [2:0] PORT_RESET  = 3'd7;

  // diskette instruction opcodes
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_SEEK   = 3'd1;
  localparam logic [2:0] OP_FORMAT = 3'd2;
  localparam logic [2:0] OP_RECAL  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_VERIFY = 3'd5;
  localparam logic [2:0] OP_WRITE  = 3'd6;

  // result byte codes
  localparam logic [7:0] ERR_NONE      = 8'h00;
  localparam logic [7:0] ERR_NOT_READY = 8'h80;
  localparam logic [7:0] ERR_ADDRESS   = 8'h08;
  localparam logic [7:0] ERR_WPROT     = 8'h20;

  localparam logic [7:0] STATUS_PRESENT = 8'h08;

  // transfer kinds
  localparam logic [1:0] XFER_TO_MEM  = 2'd0;
  localparam logic [1:0] XFER_TO_DISK = 2'd1;
  localparam logic [1:0] XFER_FILL    = 2'd2;

  // configuration register indexes
  localparam logic [0:0] CFG_DRIVE_READY   = 1'd0;
  localparam logic [0:0] CFG_WRITE_PROTECT = 1'd1;

  // drive select is one bit wide, so two slots of drive state
  localparam int DRIVE_SLOTS = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  port;
    logic [7:0]  wdata;
    logic [7:0]  instr;
    logic [7:0]  rec_count;
    logic [7:0]  track;
    logic [7:0]  sector_raw;
    logic [15:0] buf_addr;
  } item_t;

  typedef struct packed {
    logic [15:0] block_address;
    logic        int_flag;
    logic        int_status;
    logic [7:0]  error_byte;
    logic [DRIVE_SLOTS-1:0][4:0] drive_sector;
    logic [DRIVE_SLOTS-1:0][7:0] drive_cylinder;
  } state_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        fetch_req;
    logic [15:0] block_addr;
    logic        xfer_valid;
    logic [1:0]  xfer_kind;
    logic        xfer_drive;
    logic [17:0] disk_offset;
    logic [15:0] mem_addr;
    logic [11:0] xfer_len;
    logic        irq;
  } result_t;

endpackage

// ===== sv/fcru_exec.sv =====
// fcru_exec: one-pass evaluation of a port access or parameter block.
// Depends on fcru_pkg; gives next register state and the result item.
module fcru_exec #(
  parameter int SECTORS_PER_TRACK = 26,
  parameter int LAST_TRACK        = 76,
  parameter int SECTOR_BYTES      = 128,
  parameter int DRIVES            = 2
) (
  input  fcru_pkg::item_t   item_i,
  input  fcru_pkg::state_t  st_i,
  input  logic [1:0]        drive_ready_i,
  input  logic [1:0]        write_protect_i,
  output fcru_pkg::state_t  st_o,
  output fcru_pkg::result_t res_o
);

  localparam logic [4:0]  SPT_W      = 5'(SECTORS_PER_TRACK);
  localparam logic [8:0]  SPT_P1_W   = 9'(SECTORS_PER_TRACK + 1);
  localparam logic [7:0]  LAST_W     = 8'(LAST_TRACK);
  localparam logic [1:0]  DRIVES_W   = 2'(DRIVES);
  localparam logic [31:0] TRACK_B    = 32'(SECTORS_PER_TRACK * SECTOR_BYTES);
  localparam logic [31:0] SECT_B     = 32'(SECTOR_BYTES);
  localparam logic [11:0] FMT_LEN    = 12'(SECTORS_PER_TRACK * SECTOR_BYTES);

  logic [2:0]  op;
  logic        drv;
  logic [4:0]  sa;
  logic        ready_ok;
  logic        bounds_err;
  logic        wprot;
  logic [31:0] offset;
  logic [11:0] rec_len;

  assign op    = item_i.instr[2:0];
  assign drv   = item_i.instr[4];
  assign sa    = item_i.sector_raw[4:0];
  assign wprot = write_protect_i[drv];

  assign ready_ok = ({1'b0, drv} < DRIVES_W) && drive_ready_i[drv];
  assign bounds_err = (op != fcru_pkg::OP_RECAL) &&
                      ((sa > SPT_W) ||
                       ((9'(sa) + 9'(item_i.rec_count)) > SPT_P1_W) ||
                       (sa == 5'd0) || (item_i.track > LAST_W));

  // track and sector terms are scaled separately, then summed
  assign offset = 32'(item_i.track) * TRACK_B + (32'(sa) - 32'd1) * SECT_B;
  assign rec_len = 12'(32'(item_i.rec_count) * SECT_B);

  always_comb begin
    st_o  = st_i;
    res_o = '0;

    case (item_i.func)
      fcru_pkg::FUNC_PORT_RD: begin
        if (item_i.port == fcru_pkg::PORT_STATUS) begin
          res_o.read_data = fcru_pkg::STATUS_PRESENT |
                            {5'd0, st_i.int_status, drive_ready_i};
        end else if (item_i.port == fcru_pkg::PORT_RTYPE) begin
          st_o.int_flag   = 1'b0;
          st_o.int_status = 1'b0;
        end else if (item_i.port == fcru_pkg::PORT_RBYTE) begin
          res_o.read_data = st_i.error_byte;
        end
      end
      fcru_pkg::FUNC_PORT_WR: begin
        if (item_i.port == fcru_pkg::PORT_ADDR_L) begin
          st_o.block_address = {8'd0, item_i.wdata};
        end else if (item_i.port == fcru_pkg::PORT_ADDR_H) begin
          st_o.block_address = st_i.block_address | {item_i.wdata, 8'd0};
          res_o.fetch_req    = 1'b1;
          res_o.block_addr   = st_i.block_address | {item_i.wdata, 8'd0};
        end else if (item_i.port == fcru_pkg::PORT_RESET) begin
          st_o.error_byte = fcru_pkg::ERR_NONE;
          st_o.int_status = 1'b0;
        end
      end
      fcru_pkg::FUNC_BLOCK: begin
        res_o.xfer_drive  = drv;
        res_o.disk_offset = offset[17:0];
        res_o.mem_addr    = item_i.buf_addr;
        if (!ready_ok) begin
          st_o.error_byte = fcru_pkg::ERR_NOT_READY;
          st_o.int_flag   = 1'b1;
        end else if (bounds_err) begin
          st_o.error_byte = fcru_pkg::ERR_ADDRESS;
          st_o.int_flag   = 1'b1;
        end else begin
          case (op)
            fcru_pkg::OP_NOP, fcru_pkg::OP_VERIFY: begin
              st_o.error_byte = fcru_pkg::ERR_NONE;
              st_o.int_flag   = 1'b1;
            end
            fcru_pkg::OP_SEEK: begin
              st_o.drive_sector[drv]   = sa;
              st_o.drive_cylinder[drv] = item_i.track;
              st_o.error_byte          = fcru_pkg::ERR_NONE;
              st_o.int_flag            = 1'b1;
            end
            fcru_pkg::OP_RECAL: begin
              st_o.drive_sector[drv]   = sa;
              st_o.drive_cylinder[drv] = 8'd0;
              st_o.error_byte          = fcru_pkg::ERR_NONE;
              st_o.int_flag            = 1'b1;
            end
            fcru_pkg::OP_FORMAT: begin
              st_o.int_flag = 1'b1;
              if (wprot) begin
                st_o.error_byte = fcru_pkg::ERR_WPROT;
              end else begin
                st_o.error_byte  = fcru_pkg::ERR_NONE;
                res_o.xfer_valid = 1'b1;
                res_o.xfer_kind  = fcru_pkg::XFER_FILL;
                res_o.xfer_len   = FMT_LEN;
              end
            end
            fcru_pkg::OP_READ: begin
              st_o.error_byte = fcru_pkg::ERR_NONE;
              st_o.int_flag   = 1'b1;
              if (item_i.rec_count != 8'd0) begin
                res_o.xfer_valid = 1'b1;
                res_o.xfer_kind  = fcru_pkg::XFER_TO_MEM;
                res_o.xfer_len   = rec_len;
              end
            end
            fcru_pkg::OP_WRITE: begin
              st_o.int_flag = 1'b1;
              if (wprot) begin
                st_o.error_byte = fcru_pkg::ERR_WPROT;
              end else begin
                st_o.error_byte = fcru_pkg::ERR_NONE;
                if (item_i.rec_count != 8'd0) begin
                  res_o.xfer_valid = 1'b1;
                  res_o.xfer_kind  = fcru_pkg::XFER_TO_DISK;
                  res_o.xfer_len   = rec_len;
                end
              end
            end
            default: begin
              // opcode seven: checks only, state left alone
            end
          endcase
        end
        if (st_o.int_flag) begin
          st_o.int_status = 1'b1;
        end
        // descriptor fields read as zero without a transfer
        if (!res_o.xfer_valid) begin
          res_o.xfer_drive  = 1'b0;
          res_o.disk_offset = 18'd0;
          res_o.mem_addr    = 16'd0;
        end
      end
      default: begin
      end
    endcase

    res_o.irq = st_o.int_flag;
  end

endmodule

// ===== sv/floppy_command_register_unit.sv =====
// floppy_command_register_unit: top level, input and result registers,
// controller state and configuration. Depends on fcru_pkg and fcru_exec.
//
//  channel | ports                              | dir | transfer when
//  --------+------------------------------------+-----+----------------------
//  input   | in_valid/in_ready, in_<field>      | in  | in_valid & in_ready
//  result  | out_valid/out_ready, out_<field>   | out | out_valid & out_ready
//  config  | cfg_valid/cfg_ready, cfg_index/data| in  | cfg_valid & cfg_ready
//
// An item waits in the input register while the evaluation logic feeds the
// result register, and its result is valid once it enters that register. One
// item per cycle is sustained while out_ready is high; state updates as the
// item enters the result register. A stalled result holds the input register,
// and in_ready drops only when both registers are full. Reset (rst_n low,
// synchronous) clears controller state, configuration and both valid flags.
module floppy_command_register_unit #(
  parameter int SECTORS_PER_TRACK = 26,
  parameter int LAST_TRACK        = 76,
  parameter int SECTOR_BYTES      = 128,
  parameter int DRIVES            = 2
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_port,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_instr,
  input  logic [7:0]  in_rec_count,
  input  logic [7:0]  in_track,
  input  logic [7:0]  in_sector_raw,
  input  logic [15:0] in_buf_addr,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_fetch_req,
  output logic [15:0] out_block_addr,
  output logic        out_xfer_valid,
  output logic [1:0]  out_xfer_kind,
  output logic        out_xfer_drive,
  output logic [17:0] out_disk_offset,
  output logic [15:0] out_mem_addr,
  output logic [11:0] out_xfer_len,
  output logic        out_irq,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  fcru_pkg::item_t   item_r;
  fcru_pkg::state_t  st_r;
  fcru_pkg::state_t  st_nxt;
  fcru_pkg::result_t res_r;
  fcru_pkg::result_t res_nxt;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [1:0] drive_ready_r;
  logic [1:0] write_protect_r;
  logic       in_xfer;
  logic       out_free;
  logic       s1_move;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  fcru_exec #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .LAST_TRACK        (LAST_TRACK),
    .SECTOR_BYTES      (SECTOR_BYTES),
    .DRIVES            (DRIVES)
  ) u_exec (
    .item_i          (item_r),
    .st_i            (st_r),
    .drive_ready_i   (drive_ready_r),
    .write_protect_i (write_protect_r),
    .st_o            (st_nxt),
    .res_o           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      st_r            <= '0;
      drive_ready_r   <= 2'd0;
      write_protect_r <= 2'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move) begin
        st_r <= st_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          fcru_pkg::CFG_DRIVE_READY:   drive_ready_r   <= cfg_data;
          fcru_pkg::CFG_WRITE_PROTECT: write_protect_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.func       <= in_func;
      item_r.port       <= in_port;
      item_r.wdata      <= in_wdata;
      item_r.instr      <= in_instr;
      item_r.rec_count  <= in_rec_count;
      item_r.track      <= in_track;
      item_r.sector_raw <= in_sector_raw;
      item_r.buf_addr   <= in_buf_addr;
    end
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = res_r.read_data;
  assign out_fetch_req   = res_r.fetch_req;
  assign out_block_addr  = res_r.block_addr;
  assign out_xfer_valid  = res_r.xfer_valid;
  assign out_xfer_kind   = res_r.xfer_kind;
  assign out_xfer_drive  = res_r.xfer_drive;
  assign out_disk_offset = res_r.disk_offset;
  assign out_mem_addr    = res_r.mem_addr;
  assign out_xfer_len    = res_r.xfer_len;
  assign out_irq         = res_r.irq;

  // a waiting result always reflects the latest interrupt flag
  a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_irq == st_r.int_flag))
    else $error("result irq differs from interrupt flag");

  a_status_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.int_status |-> st_r.int_flag)
    else $error("interrupt status set without interrupt flag");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(item_r)))
    else $error("held item lost while result stalled");

  a_xfer_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_xfer_valid) |-> (!out_fetch_req && out_read_data == 8'd0))
    else $error("descriptor mixed with port access result");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for floppy_command_register_unit, with its own
// controller predictor, random idle bursts on both channels and config phases.
// Depends on fcru_pkg and the floppy_command_register_unit RTL.
module tb_top;

  localparam int SPT        = 26;
  localparam int LAST_TRK   = 76;
  localparam int SEC_BYTES  = 128;
  localparam int DRIVES     = 2;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 125;

  localparam logic [1:0] FUNC_IDLE         = 2'd3;
  localparam logic [2:0] OP_UNUSED         = 3'd7;

  // per-phase drive settings, two bits per phase, phase 0 in the low bits
  localparam logic [9:0] MOUNT_PLAN   = 10'b11_11_10_01_00;
  localparam logic [9:0] PROTECT_PLAN = 10'b00_11_01_10_11;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [2:0]  in_port = '0;
  logic [7:0]  in_wdata = '0;
  logic [7:0]  in_instr = '0;
  logic [7:0]  in_rec_count = '0;
  logic [7:0]  in_track = '0;
  logic [7:0]  in_sector_raw = '0;
  logic [15:0] in_buf_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_fetch_req;
  logic [15:0] out_block_addr;
  logic        out_xfer_valid;
  logic [1:0]  out_xfer_kind;
  logic        out_xfer_drive;
  logic [17:0] out_disk_offset;
  logic [15:0] out_mem_addr;
  logic [11:0] out_xfer_len;
  logic        out_irq;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [1:0]  cfg_data = '0;

  // controller state as the bench tracks it
  logic [1:0]  mounted_bits;
  logic [1:0]  protected_bits;
  logic [15:0] ctl_block_addr;
  logic        ctl_int_flag;
  logic        ctl_int_status;
  logic [7:0]  ctl_error;
  logic [4:0]  ctl_sector [DRIVES];
  logic [7:0]  ctl_cylinder [DRIVES];

  fcru_pkg::item_t   bus_items [$];
  fcru_pkg::result_t controller_responses [$];
  fcru_pkg::item_t   on_wire;
  fcru_pkg::result_t seen, want;

  int gap_left, stall_left, idle_pct, stall_pct, idle_cycles;
  int mismatches, accesses_sent, blocks_run, responses_checked;
  int descriptors_seen, command_errors;

  floppy_command_register_unit #(
    .SECTORS_PER_TRACK(SPT),
    .LAST_TRACK       (LAST_TRK),
    .SECTOR_BYTES     (SEC_BYTES),
    .DRIVES           (DRIVES)
  ) i_dut (.*);

  always #5 clk = ~clk;

  function automatic fcru_pkg::result_t controller_step(input fcru_pkg::item_t it);
    fcru_pkg::result_t r;
    logic [2:0] op;
    logic       drv;
    logic       done;
    logic [7:0] code;
    int         sec, cnt, trk, off, len;
    r = '0;
    done = 1'b0;
    code = fcru_pkg::ERR_NONE;
    case (it.func)
      fcru_pkg::FUNC_PORT_RD: begin
        case (it.port)
          fcru_pkg::PORT_STATUS: begin
            r.read_data = fcru_pkg::STATUS_PRESENT |
                          {5'd0, ctl_int_status, mounted_bits};
          end
          fcru_pkg::PORT_RTYPE: begin
            ctl_int_flag = 1'b0;
            ctl_int_status = 1'b0;
          end
          fcru_pkg::PORT_RBYTE: r.read_data = ctl_error;
          default: ;
        endcase
      end
      fcru_pkg::FUNC_PORT_WR: begin
        case (it.port)
          fcru_pkg::PORT_ADDR_L: ctl_block_addr = {8'h00, it.wdata};
          fcru_pkg::PORT_ADDR_H: begin
            ctl_block_addr = ctl_block_addr | {it.wdata, 8'h00};
            r.fetch_req = 1'b1;
            r.block_addr = ctl_block_addr;
          end
          fcru_pkg::PORT_RESET: begin
            ctl_error = fcru_pkg::ERR_NONE;
            ctl_int_status = 1'b0;
          end
          default: ;
        endcase
      end
      fcru_pkg::FUNC_BLOCK: begin
        blocks_run++;
        op  = it.instr[2:0];
        drv = it.instr[4];
        sec = int'(it.sector_raw[4:0]);
        cnt = int'(it.rec_count);
        trk = int'(it.track);
        done = 1'b1;
        if (int'(drv) >= DRIVES || !mounted_bits[drv]) begin
          code = fcru_pkg::ERR_NOT_READY;
        end else if (op != fcru_pkg::OP_RECAL &&
                     (sec == 0 || sec > SPT || sec + cnt > SPT + 1 || trk > LAST_TRK)) begin
          code = fcru_pkg::ERR_ADDRESS;
        end else if ((op == fcru_pkg::OP_FORMAT || op == fcru_pkg::OP_WRITE) &&
                     protected_bits[drv]) begin
          code = fcru_pkg::ERR_WPROT;
        end else begin
          off = (trk * SPT + sec - 1) * SEC_BYTES;
          len = (op == fcru_pkg::OP_FORMAT) ? SPT * SEC_BYTES : cnt * SEC_BYTES;
          case (op)
            fcru_pkg::OP_SEEK: begin
              ctl_sector[drv] = it.sector_raw[4:0];
              ctl_cylinder[drv] = it.track;
            end
            fcru_pkg::OP_RECAL: begin
              ctl_sector[drv] = it.sector_raw[4:0];
              ctl_cylinder[drv] = 8'h00;
            end
            fcru_pkg::OP_FORMAT, fcru_pkg::OP_READ, fcru_pkg::OP_WRITE: begin
              if (op == fcru_pkg::OP_FORMAT || cnt != 0) begin
                r.xfer_valid  = 1'b1;
                r.xfer_kind   = (op == fcru_pkg::OP_FORMAT) ? fcru_pkg::XFER_FILL :
                                (op == fcru_pkg::OP_READ)   ? fcru_pkg::XFER_TO_MEM :
                                                              fcru_pkg::XFER_TO_DISK;
                r.xfer_drive  = drv;
                r.disk_offset = off[17:0];
                r.mem_addr    = it.buf_addr;
                r.xfer_len    = len[11:0];
              end
            end
            default: ;
          endcase
          // the unused opcode leaves flag and result byte untouched
          if (op == OP_UNUSED) done = 1'b0;
        end
        if (done) begin
          if (code != fcru_pkg::ERR_NONE) command_errors++;
          ctl_error = code;
          ctl_int_flag = 1'b1;
        end
        if (ctl_int_flag) ctl_int_status = 1'b1;
      end
      default: ;
    endcase
    r.irq = ctl_int_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, exp_val));
  endtask

  function automatic fcru_pkg::item_t random_fields();
    fcru_pkg::item_t it;
    logic [31:0]     a, b;
    a = $urandom;
    b = $urandom;
    it.func       = a[1:0];
    it.port       = a[4:2];
    it.wdata      = a[12:5];
    it.instr      = a[20:13];
    it.rec_count  = a[28:21];
    it.track      = b[7:0];
    it.sector_raw = b[15:8];
    it.buf_addr   = b[31:16];
    return it;
  endfunction

  task automatic push_port(input logic [1:0] func, input logic [2:0] port,
                           input logic [7:0] wdata);
    fcru_pkg::item_t it;
    it = '0;
    it.func = func;
    it.port = port;
    it.wdata = wdata;
    bus_items.push_back(it);
  endtask

  task automatic push_block(input logic drv, input logic [2:0] op, input logic [7:0] cnt,
                            input logic [7:0] trk, input logic [7:0] sec,
                            input logic [15:0] buf_addr);
    fcru_pkg::item_t it;
    it = '0;
    it.func = fcru_pkg::FUNC_BLOCK;
    it.instr = {3'b000, drv, 1'b0, op};
    it.rec_count = cnt;
    it.track = trk;
    it.sector_raw = sec;
    it.buf_addr = buf_addr;
    bus_items.push_back(it);
  endtask

  // address low, address high, block, then one or two port reads or reset writes
  function automatic int push_command_sequence();
    fcru_pkg::item_t it;
    int              pick, sec, n, k;
    it = random_fields();
    it.func = fcru_pkg::FUNC_PORT_WR;
    it.port = fcru_pkg::PORT_ADDR_L;
    bus_items.push_back(it);
    it = random_fields();
    it.func = fcru_pkg::FUNC_PORT_WR;
    it.port = fcru_pkg::PORT_ADDR_H;
    bus_items.push_back(it);
    it = random_fields();
    it.func = fcru_pkg::FUNC_BLOCK;
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 6);
      it.instr[2:0] = pick[2:0];
      pick = $urandom_range(0, LAST_TRK);
      it.track = pick[7:0];
      sec = $urandom_range(1, SPT);
      it.sector_raw[4:0] = sec[4:0];
      pick = $urandom_range(0, SPT + 1 - sec);
      it.rec_count = pick[7:0];
    end
    bus_items.push_back(it);
    n = $urandom_range(1, 2);
    for (k = 0; k < n; k++) begin
      it = random_fields();
      pick = $urandom_range(0, 3);
      it.func = (pick == 3) ? fcru_pkg::FUNC_PORT_WR : fcru_pkg::FUNC_PORT_RD;
      it.port = (pick == 0) ? fcru_pkg::PORT_STATUS :
                (pick == 1) ? fcru_pkg::PORT_RBYTE :
                (pick == 2) ? fcru_pkg::PORT_RTYPE : fcru_pkg::PORT_RESET;
      bus_items.push_back(it);
    end
    return 3 + n;
  endfunction

  task automatic configure(input logic [1:0] ready_bits, input logic [1:0] prot_bits);
    cfg_valid <= 1'b1;
    cfg_index <= fcru_pkg::CFG_DRIVE_READY;
    cfg_data  <= ready_bits;
    do @(posedge clk); while (!cfg_ready);
    mounted_bits = ready_bits;
    cfg_index <= fcru_pkg::CFG_WRITE_PROTECT;
    cfg_data  <= prot_bits;
    do @(posedge clk); while (!cfg_ready);
    protected_bits = prot_bits;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (bus_items.size() != 0 || in_valid || controller_responses.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: predict on each input transfer, then load the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        controller_responses.push_back(controller_step(on_wire));
        accesses_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bus_items.size() != 0) begin
          on_wire = bus_items.pop_front();
          in_func       <= on_wire.func;
          in_port       <= on_wire.port;
          in_wdata      <= on_wire.wdata;
          in_instr      <= on_wire.instr;
          in_rec_count  <= on_wire.rec_count;
          in_track      <= on_wire.track;
          in_sector_raw <= on_wire.sector_raw;
          in_buf_addr   <= on_wire.buf_addr;
          in_valid      <= 1'b1;
          if ($urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_read_data, out_fetch_req, out_block_addr, out_xfer_valid, out_xfer_kind,
                out_xfer_drive, out_disk_offset, out_mem_addr, out_xfer_len, out_irq};
        if (controller_responses.size() == 0) begin
          report_mismatch("result transfer with no prediction pending");
        end else begin
          want = controller_responses.pop_front();
          responses_checked++;
          if (want.xfer_valid) descriptors_seen++;
          check_field("read_data", 32'(seen.read_data), 32'(want.read_data));
          check_field("fetch_req", 32'(seen.fetch_req), 32'(want.fetch_req));
          check_field("block_addr", 32'(seen.block_addr), 32'(want.block_addr));
          check_field("xfer_valid", 32'(seen.xfer_valid), 32'(want.xfer_valid));
          check_field("xfer_kind", 32'(seen.xfer_kind), 32'(want.xfer_kind));
          check_field("xfer_drive", 32'(seen.xfer_drive), 32'(want.xfer_drive));
          check_field("disk_offset", 32'(seen.disk_offset), 32'(want.disk_offset));
          check_field("mem_addr", 32'(seen.mem_addr), 32'(want.mem_addr));
          check_field("xfer_len", 32'(seen.xfer_len), 32'(want.xfer_len));
          check_field("irq", 32'(seen.irq), 32'(want.irq));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p, queued;
    mounted_bits = '0;
    protected_bits = '0;
    ctl_block_addr = '0;
    ctl_int_flag = 1'b0;
    ctl_int_status = 1'b0;
    ctl_error = fcru_pkg::ERR_NONE;
    for (p = 0; p < DRIVES; p++) begin
      ctl_sector[p] = '0;
      ctl_cylinder[p] = '0;
    end
    idle_pct = 30;
    stall_pct = 30;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both drives mounted, drive 1 write protected
    configure(2'b11, 2'b10);
    push_port(fcru_pkg::FUNC_PORT_WR, fcru_pkg::PORT_ADDR_L, 8'hff);
    push_port(fcru_pkg::FUNC_PORT_WR, fcru_pkg::PORT_ADDR_H, 8'hff);
    push_port(fcru_pkg::FUNC_PORT_WR, fcru_pkg::PORT_ADDR_L, 8'h00);
    push_port(fcru_pkg::FUNC_PORT_WR, fcru_pkg::PORT_ADDR_H, 8'h00);
    push_port(fcru_pkg::FUNC_PORT_RD, fcru_pkg::PORT_STATUS, 8'h00);
    push_block(1'b0, fcru_pkg::OP_NOP, 8'd0, 8'd0, 8'd1, 16'h0000);
    push_block(1'b1, fcru_pkg::OP_SEEK, 8'd1, 8'd76, 8'd26, 16'h1234);
    push_block(1'b0, fcru_pkg::OP_FORMAT, 8'd0, 8'd76, 8'he1, 16'hffff);
    push_block(1'b1, fcru_pkg::OP_FORMAT, 8'd0, 8'd0, 8'd1, 16'h0000);
    // recalibrate skips the bounds check entirely
    push_block(1'b0, fcru_pkg::OP_RECAL, 8'hff, 8'hff, 8'h00, 16'h0000);
    push_block(1'b1, fcru_pkg::OP_READ, 8'd26, 8'd0, 8'd1, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_READ, 8'd0, 8'd10, 8'd5, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_VERIFY, 8'd3, 8'd40, 8'd7, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_WRITE, 8'd22, 8'd3, 8'd5, 16'h8000);
    push_block(1'b0, fcru_pkg::OP_WRITE, 8'd0, 8'd3, 8'd5, 16'h0000);
    push_block(1'b1, fcru_pkg::OP_WRITE, 8'd1, 8'd3, 8'd5, 16'h0000);
    push_block(1'b1, OP_UNUSED, 8'd1, 8'd0, 8'd1, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_READ, 8'd1, 8'd0, 8'd0, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_READ, 8'd0, 8'd0, 8'd27, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_READ, 8'd8, 8'd0, 8'd20, 16'h0000);
    push_block(1'b0, fcru_pkg::OP_READ, 8'd1, 8'd77, 8'd1, 16'h0000);
    push_port(fcru_pkg::FUNC_PORT_RD, fcru_pkg::PORT_RBYTE, 8'h00);
    // port reset clears the result byte and interrupt status but must leave the interrupt flag raised
    push_port(fcru_pkg::FUNC_PORT_WR, fcru_pkg::PORT_RESET, 8'h00);
    push_port(fcru_pkg::FUNC_PORT_RD, fcru_pkg::PORT_RTYPE, 8'h00);
    push_port(FUNC_IDLE, fcru_pkg::PORT_RESET, 8'hff);
    drain();

    // random phases; the last one runs with no idling on either side
    for (p = 0; p < 5; p++) begin
      configure(MOUNT_PLAN[2*p +: 2], PROTECT_PLAN[2*p +: 2]);
      idle_pct  = (p == 4) ? 0 : $urandom_range(10, 50);
      stall_pct = (p == 4) ? 0 : $urandom_range(10, 50);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          queued += push_command_sequence();
        end else begin
          bus_items.push_back(random_fields());
          queued++;
        end
      end
      drain();
    end

    $display("covered %0d bus items (%0d parameter blocks) over 6 drive settings",
             accesses_sent, blocks_run);
    $display("checked %0d responses: %0d transfer descriptors, %0d rejected commands",
             responses_checked, descriptors_seen, command_errors);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
